[rtl/dhts_pkg.sv]
// Shared types, constants and the sine table function for the decaying harmonic tone synth.
// No dependencies; every other file imports this package.
package dhts_pkg;

  localparam int DEF_SINE_ADDR_BITS = 10;
  localparam int DEF_PARTIALS       = 4;
  localparam int MAX_USED           = 4;
  localparam int PART_IDX_W         = 2;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int PHASE_W    = 32;
  localparam int ENV_W      = 32;
  localparam int PEAK_W     = 15;
  localparam int SINE_W     = 15;
  localparam int SAMPLE_W   = 16;
  localparam int WEIGHT_W   = 17;
  localparam int MUL_W      = 32;
  localparam int PROD_W     = 64;
  localparam int TERM_W     = 48;
  localparam int SUM_W      = 49;
  localparam int MAG_W      = 48;
  localparam int HALF_W     = 24;
  localparam int HI_P_W     = 39;
  localparam int TOTAL_W    = 63;
  localparam int Y_W        = 18;
  localparam int Y_SHIFT    = 45;
  localparam int Q_W        = 16;

  // Division by 7 through a reciprocal; exact for any Y_W-bit quotient input (below 2^18).
  localparam int DIV7_SHIFT = 21;
  localparam int RECIP_W    = 19;
  localparam logic [RECIP_W-1:0] DIV7_RECIP = RECIP_W'(((1 << DIV7_SHIFT) + 6) / 7);

  localparam logic [Q_W-1:0]      SAMPLE_POS_MAX = 16'd32767;
  localparam logic [Q_W-1:0]      SAMPLE_NEG_MAG = 16'd32768;

  localparam logic [PHASE_W-1:0]  PHASE_STEP_RESET = 32'd42852282;
  localparam logic [PEAK_W-1:0]   PEAK_LEVEL_RESET = 15'd28000;
  localparam logic [ENV_W-1:0]    ENV_FULL         = '1;

  localparam logic [ENV_W-1:0] DECAY_RESET [MAX_USED] = '{
    32'd4294902369, 32'd4294886137, 32'd4294869905, 32'd4294845558
  };

  // Q1.16 weights 1.00, 0.40, 0.25, 0.10.
  localparam logic [WEIGHT_W-1:0] PARTIAL_WEIGHT [MAX_USED] = '{
    17'd65536, 17'd26214, 17'd16384, 17'd6554
  };

  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [63:0] ONE_Q30     = 64'd1073741824;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PHASE_STEP   = 3'd0,
    CFG_PEAK_LEVEL   = 3'd1,
    CFG_DECAY_FIRST  = 3'd2,
    CFG_DECAY_SECOND = 3'd3,
    CFG_DECAY_THIRD  = 3'd4,
    CFG_DECAY_FOURTH = 3'd5
  } cfg_reg_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_READ,
    OP_MUL_ENV,
    OP_MUL_WT,
    OP_ACC,
    OP_ABS,
    OP_HI,
    OP_LO,
    OP_SUM,
    OP_DIV,
    OP_FIN
  } dp_op_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_READ,
    S_MUL_ENV,
    S_MUL_WT,
    S_ACC,
    S_ABS,
    S_HI,
    S_LO,
    S_SUM,
    S_DIV,
    S_FIN
  } ctrl_state_t;

  typedef struct packed {
    dp_op_t                op;
    logic [PART_IDX_W-1:0] idx;
    logic                  env_wb;
  } dhts_cmd_t;

  // Quarter-wave sine magnitude in Q15 at step x of a quarter of 2^qshift steps.
  // Evaluated only at elaboration to fill the ROM: Taylor series in Q2.30.
  function automatic logic [SINE_W-1:0] sine_mag(input logic [31:0] x,
                                                 input int unsigned qshift);
    logic [63:0]        theta;
    logic [63:0]        t2;
    logic [63:0]        term;
    logic signed [63:0] acc;
    logic [63:0]        res;
    begin
      theta = ({32'b0, x} * HALF_PI_Q30) >> qshift;
      t2    = (theta * theta) >> 30;
      acc   = $signed(theta);
      term  = ((theta * t2) >> 30) / 64'd6;
      acc   = acc - $signed(term);
      term  = ((term * t2) >> 30) / 64'd20;
      acc   = acc + $signed(term);
      term  = ((term * t2) >> 30) / 64'd42;
      acc   = acc - $signed(term);
      term  = ((term * t2) >> 30) / 64'd72;
      acc   = acc + $signed(term);
      term  = ((term * t2) >> 30) / 64'd110;
      acc   = acc - $signed(term);
      term  = ((term * t2) >> 30) / 64'd156;
      acc   = acc + $signed(term);
      term  = ((term * t2) >> 30) / 64'd210;
      acc   = acc - $signed(term);
      if (acc < 0) acc = 64'sd0;
      if (acc > $signed(ONE_Q30)) acc = $signed(ONE_Q30);
      res = (($unsigned(acc) * 64'd32767) + (ONE_Q30 >> 1)) >> 30;
      return res[SINE_W-1:0];
    end
  endfunction

endpackage

[rtl/dhts_if.sv]
// Handshake channels of the tone synth: the tick input and the PCM sample output.
// Depends on dhts_pkg for the sample width.
interface dhts_tick_if;
  logic valid;
  logic ready;
  logic restart;
  modport source(output valid, output restart, input ready);
  modport sink(input valid, input restart, output ready);
endinterface

interface dhts_pcm_if import dhts_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample;
  modport source(output valid, output sample, input ready);
  modport sink(input valid, input sample, output ready);
endinterface

[rtl/decaying_harmonic_tone_synth.sv]
// Decaying harmonic tone synth: each tick item yields one signed 16-bit PCM sample built
// from up to four sine partials, each with its own exponential decay envelope. A tick
// with restart set zeroes the phase and returns every envelope to full scale before the
// sample is formed. Per partial the steps are read, envelope scaling, weighting and
// accumulation; then come absolute value, high and low level scaling, sum, divide and the
// final step, which waits until the output register is free and then loads the sample.
// No tick is taken mid-sample; the next is taken in the cycle after the final step.
// The single shared 32x32 multiplier serves the envelope scaling, the weighting, the
// envelope decay update, the output level scaling and the division by seven in turn.
// The output register holds a finished sample while a new tick is taken. Configuration
// writes go through cfg_we, cfg_index and cfg_data and must only be made while the block
// is idle; writes to an index past the last register are ignored.
module decaying_harmonic_tone_synth import dhts_pkg::*; #(
  parameter int SINE_ADDR_BITS = DEF_SINE_ADDR_BITS,
  parameter int PARTIALS       = DEF_PARTIALS
) (
  input logic                  clk,
  input logic                  rst,
  dhts_tick_if.sink            tick,
  dhts_pcm_if.source           pcm,
  input logic                  cfg_we,
  input logic [CFG_IDX_W-1:0]  cfg_index,
  input logic [CFG_DATA_W-1:0] cfg_data
);

  dhts_cmd_t cmd;

  dhts_ctrl #(
    .PARTIALS (PARTIALS)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (tick.valid),
    .in_ready  (tick.ready),
    .out_valid (pcm.valid),
    .out_ready (pcm.ready),
    .cmd       (cmd)
  );

  dhts_datapath #(
    .SINE_ADDR_BITS (SINE_ADDR_BITS),
    .PARTIALS       (PARTIALS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .restart   (tick.restart),
    .cmd       (cmd),
    .sample    (pcm.sample)
  );

  // A new sample appears only right after the final output step.
  a_valid_after_fin: assert property (@(posedge clk) disable iff (rst)
    $rose(pcm.valid) |-> $past(cmd.op == OP_FIN))
    else $error("output valid rose without a final step");

  // The final step always leaves a sample waiting.
  a_fin_sets_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.op == OP_FIN |=> pcm.valid)
    else $error("final step did not present a sample");

  // An accepted tick must start the datapath.
  a_accept_loads: assert property (@(posedge clk) disable iff (rst)
    (tick.valid && tick.ready) |-> cmd.op == OP_LOAD)
    else $error("tick accepted without a load command");

  // Envelope write-back only happens where the multiplier is idle and holds a decay product.
  a_wb_slot: assert property (@(posedge clk) disable iff (rst)
    cmd.env_wb |-> (cmd.op == OP_READ || cmd.op == OP_ABS))
    else $error("envelope write-back outside its slot");

endmodule

[rtl/dhts_ctrl.sv]
// Sequencer of the tone synth: walks the partials and the output scaling steps,
// issues one datapath command per cycle and runs both handshakes. Uses dhts_pkg.
module dhts_ctrl import dhts_pkg::*; #(
  parameter int PARTIALS = DEF_PARTIALS
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  output dhts_cmd_t cmd
);

  localparam int USED  = (PARTIALS < MAX_USED) ? PARTIALS : MAX_USED;
  localparam int IDX_W = (USED > 1) ? $clog2(USED) : 1;
  localparam logic [IDX_W-1:0] LAST = IDX_W'(USED - 1);

  ctrl_state_t      state, state_next;
  logic [IDX_W-1:0] k, k_next;
  logic             out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      k         <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      k         <= k_next;
      out_valid <= out_valid_next;
    end
  end

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next     = state;
    k_next         = k;
    out_valid_next = out_valid && !out_ready;
    cmd.op         = OP_NONE;
    cmd.idx        = PART_IDX_W'(k);
    cmd.env_wb     = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op     = OP_LOAD;
          k_next     = '0;
          state_next = S_READ;
        end
      end
      S_READ: begin
        cmd.op     = OP_READ;
        // The previous partial's decayed envelope is written back here.
        cmd.env_wb = (k != '0);
        state_next = S_MUL_ENV;
      end
      S_MUL_ENV: begin
        cmd.op     = OP_MUL_ENV;
        state_next = S_MUL_WT;
      end
      S_MUL_WT: begin
        cmd.op     = OP_MUL_WT;
        state_next = S_ACC;
      end
      S_ACC: begin
        cmd.op = OP_ACC;
        if (k == LAST) begin
          state_next = S_ABS;
        end else begin
          k_next     = k + IDX_W'(1);
          state_next = S_READ;
        end
      end
      S_ABS: begin
        cmd.op     = OP_ABS;
        cmd.env_wb = 1'b1;
        state_next = S_HI;
      end
      S_HI: begin
        cmd.op     = OP_HI;
        state_next = S_LO;
      end
      S_LO: begin
        cmd.op     = OP_LO;
        state_next = S_SUM;
      end
      S_SUM: begin
        cmd.op     = OP_SUM;
        state_next = S_DIV;
      end
      S_DIV: begin
        cmd.op     = OP_DIV;
        state_next = S_FIN;
      end
      S_FIN: begin
        // Hold until the output register is free.
        if (!out_valid || out_ready) begin
          cmd.op         = OP_FIN;
          out_valid_next = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

[rtl/dhts_datapath.sv]
// Datapath of the tone synth: configuration registers, phase and envelopes, sine ROM,
// one shared 32x32 multiplier, the signed accumulator and the output register. Uses dhts_pkg.
module dhts_datapath import dhts_pkg::*; #(
  parameter int SINE_ADDR_BITS = DEF_SINE_ADDR_BITS,
  parameter int PARTIALS       = DEF_PARTIALS
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [CFG_IDX_W-1:0]       cfg_index,
  input  logic [CFG_DATA_W-1:0]      cfg_data,
  input  logic                       restart,
  input  dhts_cmd_t                  cmd,
  output logic signed [SAMPLE_W-1:0] sample
);

  localparam int USED   = (PARTIALS < MAX_USED) ? PARTIALS : MAX_USED;
  localparam int IDX_W  = (USED > 1) ? $clog2(USED) : 1;
  localparam int QSHIFT = SINE_ADDR_BITS - 2;
  localparam int QSIZE  = 1 << QSHIFT;

  // Configuration and note state.
  logic [PHASE_W-1:0] phase_step;
  logic [PEAK_W-1:0]  peak_level;
  logic [ENV_W-1:0]   decay [USED];
  logic [PHASE_W-1:0] phase;
  logic [ENV_W-1:0]   env [USED];

  // Working registers.
  logic [PHASE_W-1:0]      pk;
  logic [SINE_W-1:0]       rom_q;
  logic                    neg_q;
  logic [IDX_W-1:0]        wb_idx;
  logic signed [SUM_W-1:0] sum;
  logic                    neg_out;
  logic [MAG_W-1:0]        mag;
  logic [HI_P_W-1:0]       hi_p;
  logic [Y_W-1:0]          y;
  logic [PROD_W-1:0]       prod;

  logic [IDX_W-1:0]          ix;
  logic [CFG_IDX_W-1:0]      didx;
  logic [SINE_ADDR_BITS-1:0] addr;
  logic [1:0]                quad;
  logic [QSHIFT:0]           rom_x;
  logic [MUL_W-1:0]          mul_a, mul_b;
  logic [PROD_W-1:0]         mul_p;
  logic [TERM_W-1:0]         term;
  logic [TOTAL_W-1:0]        total;
  logic [Q_W-1:0]            quo;
  logic [Q_W:0]              mag_s;
  logic [SAMPLE_W-1:0]       sample_v;

  // Quarter-wave table, constant after elaboration.
  logic [SINE_W-1:0] quarter_rom [QSIZE+1];

  for (genvar gi = 0; gi <= QSIZE; gi++) begin : g_rom
    assign quarter_rom[gi] = sine_mag(32'(gi), QSHIFT);
  end

  assign ix   = cmd.idx[IDX_W-1:0];
  assign didx = CFG_IDX_W'(cfg_index - CFG_DECAY_FIRST);
  assign addr = pk[PHASE_W-1 -: SINE_ADDR_BITS];
  assign quad = addr[SINE_ADDR_BITS-1 -: 2];
  // Odd quadrants run the table backwards.
  assign rom_x = quad[0] ? ((QSHIFT+1)'(QSIZE) - {1'b0, addr[QSHIFT-1:0]})
                         : {1'b0, addr[QSHIFT-1:0]};

  assign term  = prod[TERM_W-1:0];
  assign total = {hi_p, {HALF_W{1'b0}}} + {{HALF_W{1'b0}}, prod[HI_P_W-1:0]};
  assign quo   = prod[DIV7_SHIFT + Q_W - 1 : DIV7_SHIFT];

  // Shared multiplier operand selection.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (cmd.op)
      OP_MUL_ENV: begin
        mul_a = MUL_W'(rom_q);
        mul_b = env[ix];
      end
      OP_MUL_WT: begin
        mul_a = MUL_W'(prod[TERM_W-2:16]);
        mul_b = MUL_W'(PARTIAL_WEIGHT[cmd.idx]);
      end
      OP_ACC: begin
        mul_a = env[ix];
        mul_b = decay[ix];
      end
      OP_HI: begin
        mul_a = MUL_W'(mag[MAG_W-1:HALF_W]);
        mul_b = MUL_W'(peak_level);
      end
      OP_LO: begin
        mul_a = MUL_W'(mag[HALF_W-1:0]);
        mul_b = MUL_W'(peak_level);
      end
      OP_DIV: begin
        mul_a = MUL_W'(y);
        mul_b = MUL_W'(DIV7_RECIP);
      end
      default: ;
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // Truncate toward zero already happened in magnitude; now saturate and apply sign.
  always_comb begin
    if (neg_out) begin
      mag_s    = (quo > SAMPLE_NEG_MAG) ? {1'b0, SAMPLE_NEG_MAG} : {1'b0, quo};
      sample_v = SAMPLE_W'(-mag_s);
    end else begin
      mag_s    = (quo > SAMPLE_POS_MAX) ? {1'b0, SAMPLE_POS_MAX} : {1'b0, quo};
      sample_v = mag_s[SAMPLE_W-1:0];
    end
  end

  // Configuration, phase and envelope state.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase_step <= PHASE_STEP_RESET;
      peak_level <= PEAK_LEVEL_RESET;
      phase      <= '0;
      for (int i = 0; i < USED; i++) begin
        decay[i] <= DECAY_RESET[i];
        env[i]   <= ENV_FULL;
      end
    end else begin
      if (cfg_we) begin
        unique case (cfg_index) inside
          CFG_PHASE_STEP: phase_step <= cfg_data[PHASE_W-1:0];
          CFG_PEAK_LEVEL: peak_level <= cfg_data[PEAK_W-1:0];
          CFG_DECAY_FIRST, CFG_DECAY_SECOND, CFG_DECAY_THIRD, CFG_DECAY_FOURTH: begin
            if (int'(didx) < USED) decay[didx[IDX_W-1:0]] <= cfg_data[ENV_W-1:0];
          end
          default: ;
        endcase
      end
      if (cmd.op == OP_LOAD && restart) begin
        phase <= '0;
        for (int i = 0; i < USED; i++) env[i] <= ENV_FULL;
      end
      if (cmd.env_wb) env[wb_idx] <= prod[PROD_W-1:ENV_W];
      if (cmd.op == OP_FIN) phase <= phase + phase_step;
    end
  end

  // Per-item working registers.
  always_ff @(posedge clk) begin
    unique case (cmd.op) inside
      OP_LOAD: begin
        pk  <= restart ? '0 : phase;
        sum <= '0;
      end
      OP_READ: begin
        rom_q <= quarter_rom[rom_x];
        neg_q <= quad[1];
        // Partial k+1 reads the ROM at phase times k+1.
        pk    <= pk + phase;
      end
      OP_MUL_ENV, OP_MUL_WT, OP_HI, OP_DIV: prod <= mul_p;
      OP_ACC: begin
        sum    <= neg_q ? (sum - $signed({1'b0, term})) : (sum + $signed({1'b0, term}));
        wb_idx <= ix;
        prod   <= mul_p;
      end
      OP_ABS: begin
        mag     <= sum[SUM_W-1] ? MAG_W'(-sum) : MAG_W'(sum);
        neg_out <= sum[SUM_W-1];
      end
      OP_LO: begin
        hi_p <= prod[HI_P_W-1:0];
        prod <= mul_p;
      end
      OP_SUM: y <= total[TOTAL_W-1:Y_SHIFT];
      OP_FIN: sample <= sample_v;
      default: ;
    endcase
  end

endmodule
